/* rtl/pomodoro_phase_timer_top_assert.svh */
// Assertion macros for the phase timer checker.
`ifndef POMODORO_PHASE_TIMER_TOP_ASSERT_SVH
`define POMODORO_PHASE_TIMER_TOP_ASSERT_SVH

// Checks a property on every rising edge of clk while arst_n is high.
`define PPT_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks a property that only applies while a result beat is offered.
`define PPT_CHECK_OUT(lbl, prop, msg) \
	`PPT_CHECK(lbl, out_valid |-> (prop), msg)

`endif

/* rtl/ppt_pkg.sv */
`timescale 1ns / 1ps
package ppt_pkg;

	localparam int CYCLE_STEPS_DEF = 8;

	localparam int NOW_W  = 48;
	localparam int DL_W   = 49;
	localparam int LEFT_W = 33;
	localparam int MIN_W  = 7;
	localparam int PM_W   = 10;
	localparam int REM_W  = 44;
	localparam int IDX_W  = 2;

	localparam logic [LEFT_W-1:0] US_PER_MIN = LEFT_W'(60000000);
	localparam logic [PM_W-1:0]   PERMILLE   = PM_W'(1000);

	localparam logic [MIN_W-1:0] FOCUS_RST = MIN_W'(25);
	localparam logic [MIN_W-1:0] SHORT_RST = MIN_W'(5);
	localparam logic [MIN_W-1:0] LONG_RST  = MIN_W'(15);

	localparam logic [IDX_W-1:0] REG_FOCUS = 2'd0;
	localparam logic [IDX_W-1:0] REG_SHORT = 2'd1;
	localparam logic [IDX_W-1:0] REG_LONG  = 2'd2;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_TAP   = 2'd1;
	localparam logic [1:0] CMD_RESET = 2'd2;

	localparam logic [1:0] RUN_IDLE    = 2'd0;
	localparam logic [1:0] RUN_RUNNING = 2'd1;
	localparam logic [1:0] RUN_PAUSED  = 2'd2;
	localparam logic [1:0] RUN_DONE    = 2'd3;

	localparam logic [1:0] KIND_FOCUS = 2'd0;
	localparam logic [1:0] KIND_SHORT = 2'd1;
	localparam logic [1:0] KIND_LONG  = 2'd2;

	typedef struct packed {
		logic [MIN_W-1:0] focus;
		logic [MIN_W-1:0] short_brk;
		logic [MIN_W-1:0] long_brk;
	} cfg_t;

	typedef struct packed {
		logic [DL_W-1:0] a;
		logic [DL_W-1:0] b;
		logic            sub;
	} alu_req_t;

	typedef struct packed {
		logic [DL_W-1:0] sum;
		logic            carry;
	} alu_rsp_t;

endpackage

/* rtl/ppt_if.sv */
`timescale 1ns / 1ps
interface ppt_in_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 cmd;
	logic [ppt_pkg::NOW_W-1:0]  now_us;

	modport source(output valid, cmd, now_us, input ready);
	modport sink(input valid, cmd, now_us, output ready);
endinterface

interface ppt_out_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 timer_state;
	logic [2:0]                 step_index;
	logic [1:0]                 phase_kind;
	logic [ppt_pkg::LEFT_W-1:0] time_left_us;
	logic                       fraction_valid;
	logic [ppt_pkg::PM_W-1:0]   fraction_permille;
	logic                       just_expired;

	modport source(output valid, timer_state, step_index, phase_kind, time_left_us,
		fraction_valid, fraction_permille, just_expired, input ready);
	modport sink(input valid, timer_state, step_index, phase_kind, time_left_us,
		fraction_valid, fraction_permille, just_expired, output ready);
endinterface

/* rtl/ppt_alu.sv */
`timescale 1ns / 1ps
module ppt_alu (
	input  ppt_pkg::alu_req_t req,
	output ppt_pkg::alu_rsp_t rsp
);
	logic [ppt_pkg::DL_W:0] res;

	always_comb begin
		if (req.sub) begin
			res = {1'b0, req.a} - {1'b0, req.b};
		end else begin
			res = {1'b0, req.a} + {1'b0, req.b};
		end
		rsp.sum   = res[ppt_pkg::DL_W-1:0];
		rsp.carry = res[ppt_pkg::DL_W];
	end
endmodule

/* rtl/ppt_ctrl.sv */
`timescale 1ns / 1ps
module ppt_ctrl #(
	parameter int CYCLE_STEPS = ppt_pkg::CYCLE_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ppt_pkg::cfg_t     cfg,
	output ppt_pkg::alu_req_t alu_req,
	input  ppt_pkg::alu_rsp_t alu_rsp,
	ppt_in_if.sink            in_ch,
	ppt_out_if.source         out_ch
);
	localparam int STEP_W    = (CYCLE_STEPS > 2) ? $clog2(CYCLE_STEPS) : 1;
	localparam int DIV_STEPS = ppt_pkg::PM_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int DIV_W     = ppt_pkg::LEFT_W + DIV_STEPS - 1;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CYCLE_STEPS - 1);

	localparam logic [2:0] SQ_WAIT = 3'd0;
	localparam logic [2:0] SQ_EXP  = 3'd1;
	localparam logic [2:0] SQ_UPD  = 3'd2;
	localparam logic [2:0] SQ_LEFT = 3'd3;
	localparam logic [2:0] SQ_CMP  = 3'd4;
	localparam logic [2:0] SQ_MUL  = 3'd5;
	localparam logic [2:0] SQ_DIV  = 3'd6;
	localparam logic [2:0] SQ_FIN  = 3'd7;

	localparam logic [1:0] OP_NONE   = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_PAUSE  = 2'd2;
	localparam logic [1:0] OP_RESUME = 2'd3;

	logic [2:0]                   sq_q;
	logic [1:0]                   cmd_q;
	logic [ppt_pkg::NOW_W-1:0]    now_q;
	logic [1:0]                   run_q;
	logic [ppt_pkg::DL_W-1:0]     deadline_q;
	logic [ppt_pkg::LEFT_W-1:0]   paused_q;
	logic [ppt_pkg::LEFT_W-1:0]   total_q;
	logic [STEP_W-1:0]            step_q;
	logic                         expired_q;
	logic [1:0]                   op_q;
	logic [ppt_pkg::LEFT_W-1:0]   dur_q;
	logic [ppt_pkg::LEFT_W-1:0]   left_q;
	logic                         fv_q;
	logic                         clamp_q;
	logic [ppt_pkg::REM_W-1:0]    rem_q;
	logic [DIV_W-1:0]             div_q;
	logic [ppt_pkg::PM_W-1:0]     quo_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         out_vld_q;

	logic [1:0]                   kind;
	logic [ppt_pkg::MIN_W-1:0]    minutes;
	logic [ppt_pkg::LEFT_W-1:0]   dur;
	logic [ppt_pkg::PM_W-1:0]     permille;
	logic                         load_out;

	always_comb begin
		if (step_q == LAST_STEP) begin
			kind = ppt_pkg::KIND_LONG;
		end else if (step_q[0]) begin
			kind = ppt_pkg::KIND_SHORT;
		end else begin
			kind = ppt_pkg::KIND_FOCUS;
		end
		unique case (kind)
			ppt_pkg::KIND_FOCUS: minutes = cfg.focus;
			ppt_pkg::KIND_SHORT: minutes = cfg.short_brk;
			default:             minutes = cfg.long_brk;
		endcase
		dur = ppt_pkg::LEFT_W'(minutes) * ppt_pkg::US_PER_MIN;
	end

	always_comb begin
		alu_req = '0;
		unique case (sq_q)
			SQ_EXP: begin
				alu_req.a   = ppt_pkg::DL_W'(now_q);
				alu_req.b   = deadline_q;
				alu_req.sub = 1'b1;
			end
			SQ_UPD: begin
				unique case (op_q)
					OP_START: begin
						alu_req.a = ppt_pkg::DL_W'(now_q);
						alu_req.b = ppt_pkg::DL_W'(dur_q);
					end
					OP_PAUSE: begin
						alu_req.a   = deadline_q;
						alu_req.b   = ppt_pkg::DL_W'(now_q);
						alu_req.sub = 1'b1;
					end
					OP_RESUME: begin
						alu_req.a = ppt_pkg::DL_W'(now_q);
						alu_req.b = ppt_pkg::DL_W'(paused_q);
					end
					default: alu_req = '0;
				endcase
			end
			SQ_LEFT: begin
				alu_req.a   = deadline_q;
				alu_req.b   = ppt_pkg::DL_W'(now_q);
				alu_req.sub = 1'b1;
			end
			SQ_CMP: begin
				alu_req.a   = ppt_pkg::DL_W'(left_q);
				alu_req.b   = ppt_pkg::DL_W'(total_q);
				alu_req.sub = 1'b1;
			end
			SQ_DIV: begin
				alu_req.a   = ppt_pkg::DL_W'(rem_q);
				alu_req.b   = ppt_pkg::DL_W'(div_q);
				alu_req.sub = 1'b1;
			end
			default: alu_req = '0;
		endcase
	end

	always_comb begin
		if (!fv_q) begin
			permille = '0;
		end else if (clamp_q) begin
			permille = ppt_pkg::PERMILLE;
		end else begin
			permille = quo_q + ppt_pkg::PM_W'(rem_q != '0);
		end
	end

	assign load_out    = (sq_q == SQ_FIN) && (!out_vld_q || out_ch.ready);
	assign in_ch.ready = (sq_q == SQ_WAIT);
	assign out_ch.valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q       <= SQ_WAIT;
			run_q      <= ppt_pkg::RUN_IDLE;
			deadline_q <= '0;
			paused_q   <= '0;
			total_q    <= '0;
			step_q     <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (sq_q)
				SQ_WAIT: begin
					if (in_ch.valid) begin
						sq_q <= SQ_EXP;
					end
				end
				SQ_EXP: begin
					sq_q <= SQ_UPD;
					if (cmd_q == ppt_pkg::CMD_RESET) begin
						run_q      <= ppt_pkg::RUN_IDLE;
						deadline_q <= '0;
						paused_q   <= '0;
						total_q    <= '0;
						step_q     <= '0;
					end else if (run_q == ppt_pkg::RUN_RUNNING && !alu_rsp.carry) begin
						run_q <= ppt_pkg::RUN_DONE;
					end else if (cmd_q == ppt_pkg::CMD_TAP && run_q == ppt_pkg::RUN_DONE) begin
						run_q      <= ppt_pkg::RUN_IDLE;
						deadline_q <= '0;
						paused_q   <= '0;
						total_q    <= '0;
						step_q     <= (step_q == LAST_STEP) ? '0 : step_q + 1'b1;
					end
				end
				SQ_UPD: begin
					sq_q <= SQ_LEFT;
					unique case (op_q)
						OP_START: begin
							run_q      <= ppt_pkg::RUN_RUNNING;
							deadline_q <= alu_rsp.sum;
							paused_q   <= '0;
							total_q    <= dur_q;
						end
						OP_PAUSE: begin
							run_q    <= ppt_pkg::RUN_PAUSED;
							paused_q <= alu_rsp.sum[ppt_pkg::LEFT_W-1:0];
						end
						OP_RESUME: begin
							run_q      <= ppt_pkg::RUN_RUNNING;
							deadline_q <= alu_rsp.sum;
						end
						default: begin
						end
					endcase
				end
				SQ_LEFT: sq_q <= SQ_CMP;
				SQ_CMP: begin
					if (!fv_q || !alu_rsp.carry) begin
						sq_q <= SQ_FIN;
					end else begin
						sq_q <= SQ_MUL;
					end
				end
				SQ_MUL: sq_q <= SQ_DIV;
				SQ_DIV: begin
					if (cnt_q == '0) begin
						sq_q <= SQ_FIN;
					end
				end
				default: begin
					if (load_out) begin
						sq_q <= SQ_WAIT;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (sq_q)
			SQ_WAIT: begin
				cmd_q <= in_ch.cmd;
				now_q <= in_ch.now_us;
			end
			SQ_EXP: begin
				dur_q <= dur;
				if (cmd_q == ppt_pkg::CMD_RESET) begin
					op_q      <= OP_NONE;
					expired_q <= 1'b0;
				end else if (run_q == ppt_pkg::RUN_RUNNING && !alu_rsp.carry) begin
					op_q      <= OP_NONE;
					expired_q <= 1'b1;
				end else if (cmd_q == ppt_pkg::CMD_TAP) begin
					expired_q <= 1'b0;
					unique case (run_q)
						ppt_pkg::RUN_IDLE:    op_q <= (minutes != '0) ? OP_START : OP_NONE;
						ppt_pkg::RUN_RUNNING: op_q <= OP_PAUSE;
						ppt_pkg::RUN_PAUSED:  op_q <= OP_RESUME;
						default:              op_q <= OP_NONE;
					endcase
				end else begin
					op_q      <= OP_NONE;
					expired_q <= 1'b0;
				end
			end
			SQ_LEFT: begin
				fv_q <= (run_q == ppt_pkg::RUN_RUNNING || run_q == ppt_pkg::RUN_PAUSED)
					&& (total_q != '0);
				if (run_q == ppt_pkg::RUN_RUNNING) begin
					left_q <= alu_rsp.carry ? '0 : alu_rsp.sum[ppt_pkg::LEFT_W-1:0];
				end else if (run_q == ppt_pkg::RUN_PAUSED) begin
					left_q <= paused_q;
				end else begin
					left_q <= '0;
				end
			end
			SQ_CMP: begin
				clamp_q <= !alu_rsp.carry;
			end
			SQ_MUL: begin
				rem_q <= ppt_pkg::REM_W'(left_q) * ppt_pkg::REM_W'(ppt_pkg::PERMILLE);
				div_q <= DIV_W'(total_q) << (DIV_STEPS - 1);
				quo_q <= '0;
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end
			SQ_DIV: begin
				if (!alu_rsp.carry) begin
					rem_q <= alu_rsp.sum[ppt_pkg::REM_W-1:0];
				end
				quo_q <= {quo_q[ppt_pkg::PM_W-2:0], !alu_rsp.carry};
				div_q <= div_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ch.timer_state       <= run_q;
			out_ch.step_index        <= 3'(step_q);
			out_ch.phase_kind        <= kind;
			out_ch.time_left_us      <= left_q;
			out_ch.fraction_valid    <= fv_q;
			out_ch.fraction_permille <= permille;
			out_ch.just_expired      <= expired_q;
		end
	end
endmodule

/* rtl/pomodoro_phase_timer_top.sv */
`timescale 1ns / 1ps
// Steps: after an input beat is taken, expiry check, update, time left and compare run, then
// a multiply and a ten-step restoring division if the fraction needs them; all steps but the
// multiply share one 49-bit adder/subtractor. No new input is taken until the result loads.
// Reset: arst_n clears the timer to idle at step zero, restores the default phase lengths
// and drops the result beat; there is no clearing pass.
module pomodoro_phase_timer_top #(
	parameter int CYCLE_STEPS = ppt_pkg::CYCLE_STEPS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	ppt_in_if.sink                    in_ch,
	ppt_out_if.source                 out_ch,
	input  logic                      wr_en,
	input  logic [ppt_pkg::IDX_W-1:0] wr_index,
	input  logic [ppt_pkg::MIN_W-1:0] wr_data
);
	ppt_pkg::cfg_t     cfg_q;
	ppt_pkg::alu_req_t alu_req;
	ppt_pkg::alu_rsp_t alu_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focus     <= ppt_pkg::FOCUS_RST;
			cfg_q.short_brk <= ppt_pkg::SHORT_RST;
			cfg_q.long_brk  <= ppt_pkg::LONG_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				ppt_pkg::REG_FOCUS: cfg_q.focus     <= wr_data;
				ppt_pkg::REG_SHORT: cfg_q.short_brk <= wr_data;
				ppt_pkg::REG_LONG:  cfg_q.long_brk  <= wr_data;
				default: begin
				end
			endcase
		end
	end

	ppt_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	ppt_ctrl #(
		.CYCLE_STEPS (CYCLE_STEPS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.alu_req (alu_req),
		.alu_rsp (alu_rsp),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);
endmodule

/* rtl/ppt_chk.sv */
`timescale 1ns / 1ps
`include "pomodoro_phase_timer_top_assert.svh"
module ppt_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [1:0]                 timer_state,
	input logic [ppt_pkg::LEFT_W-1:0] time_left_us,
	input logic                       fraction_valid,
	input logic [ppt_pkg::PM_W-1:0]   fraction_permille,
	input logic                       just_expired
);
	logic live;

	assign live = (timer_state == ppt_pkg::RUN_RUNNING) || (timer_state == ppt_pkg::RUN_PAUSED);

	`PPT_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(time_left_us), "beat changed")
	`PPT_CHECK_OUT(a_pm_range, fraction_permille <= ppt_pkg::PERMILLE, "permille above 1000")
	`PPT_CHECK_OUT(a_pm_zero, fraction_valid || fraction_permille == '0, "permille without valid")
	`PPT_CHECK_OUT(a_exp_done, !just_expired || timer_state == ppt_pkg::RUN_DONE, "expiry not done")
	`PPT_CHECK_OUT(a_idle_zero, live || (time_left_us == '0 && !fraction_valid), "time left while idle")
endmodule

bind pomodoro_phase_timer_top ppt_chk u_ppt_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_ch.valid),
	.out_ready         (out_ch.ready),
	.timer_state       (out_ch.timer_state),
	.time_left_us      (out_ch.time_left_us),
	.fraction_valid    (out_ch.fraction_valid),
	.fraction_permille (out_ch.fraction_permille),
	.just_expired      (out_ch.just_expired)
);

/* dv/pomodoro_phase_timer_top_test.sv */
`timescale 1ns / 1ps
module pomodoro_phase_timer_top_test;
	import ppt_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam logic [NOW_W-1:0] NOW_TOP = '1;
	localparam logic [63:0] MICROS_PER_MINUTE = 64'd60000000;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		logic [1:0]        run_st;
		logic [2:0]        step;
		logic [1:0]        kind;
		logic [LEFT_W-1:0] left;
		logic              fvalid;
		logic [PM_W-1:0]   permille;
		logic              expired;
	} timer_report_t;

	class phase_timer_scoreboard;
		logic [1:0]        run_st;
		logic [DL_W-1:0]   deadline;
		logic [LEFT_W-1:0] held_left;
		logic [LEFT_W-1:0] total;
		logic [2:0]        step;
		logic [MIN_W-1:0]  minutes [3];
		timer_report_t     awaited [$];
		int                errors;

		function new();
			run_st = RUN_IDLE;
			deadline = '0;
			held_left = '0;
			total = '0;
			step = '0;
			minutes[REG_FOCUS] = FOCUS_RST;
			minutes[REG_SHORT] = SHORT_RST;
			minutes[REG_LONG] = LONG_RST;
			errors = 0;
		endfunction

		function void set_minutes(logic [IDX_W-1:0] idx, logic [MIN_W-1:0] val);
			if (idx == REG_FOCUS || idx == REG_SHORT || idx == REG_LONG) begin
				minutes[idx] = val;
			end
		endfunction

		function logic [1:0] kind_of(logic [2:0] s);
			if (s == 3'(CYCLE_STEPS_DEF - 1)) begin
				return KIND_LONG;
			end
			return s[0] ? KIND_SHORT : KIND_FOCUS;
		endfunction

		function bit lapse(logic [NOW_W-1:0] now);
			if (run_st == RUN_RUNNING && DL_W'(now) >= deadline) begin
				run_st = RUN_DONE;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void clear_phase();
			run_st = RUN_IDLE;
			deadline = '0;
			held_left = '0;
			total = '0;
		endfunction

		function void take_command(logic [1:0] c, logic [NOW_W-1:0] now);
			logic [63:0] dur;
			logic [63:0] left;
			logic [63:0] pm;
			bit fired;
			timer_report_t r;
			fired = 1'b0;
			if (c == CMD_RESET) begin
				clear_phase();
				step = '0;
			end else begin
				fired = lapse(now);
				if (c == CMD_TAP && !fired) begin
					case (run_st)
						RUN_IDLE: begin
							dur = 64'(minutes[kind_of(step)]) * MICROS_PER_MINUTE;
							if (dur != 0) begin
								run_st = RUN_RUNNING;
								deadline = DL_W'(now) + DL_W'(dur);
								held_left = '0;
								total = LEFT_W'(dur);
							end
						end
						RUN_RUNNING: begin
							held_left = LEFT_W'(64'(deadline) - 64'(now));
							run_st = RUN_PAUSED;
						end
						RUN_PAUSED: begin
							deadline = DL_W'(now) + DL_W'(held_left);
							run_st = RUN_RUNNING;
						end
						default: begin
							clear_phase();
							step = 3'((int'(step) + 1) % CYCLE_STEPS_DEF);
						end
					endcase
				end
			end
			left = '0;
			if (run_st == RUN_RUNNING) begin
				left = (deadline > DL_W'(now)) ? 64'(deadline) - 64'(now) : 64'd0;
			end else if (run_st == RUN_PAUSED) begin
				left = 64'(held_left);
			end
			left = 64'(LEFT_W'(left));
			pm = '0;
			r.fvalid = 1'b0;
			if ((run_st == RUN_RUNNING || run_st == RUN_PAUSED) && total != 0) begin
				r.fvalid = 1'b1;
				pm = (left * 64'd1000 + 64'(total) - 64'd1) / 64'(total);
				if (pm > 64'd1000) begin
					pm = 64'd1000;
				end
			end
			r.run_st = run_st;
			r.step = step;
			r.kind = kind_of(step);
			r.left = LEFT_W'(left);
			r.permille = PM_W'(pm);
			r.expired = fired;
			awaited.push_back(r);
		endfunction

		function void report(string what, longint unsigned want, longint unsigned got);
			$display("%0t mismatch in %s: expected %0d, got %0d", $time, what, want, got);
			errors++;
		endfunction

		function void check_report(timer_report_t got);
			timer_report_t want;
			if (awaited.size() == 0) begin
				report("result beat with nothing awaited", 0, 0);
				return;
			end
			want = awaited.pop_front();
			if (got.run_st !== want.run_st) report("timer_state", want.run_st, got.run_st);
			if (got.step !== want.step) report("step_index", want.step, got.step);
			if (got.kind !== want.kind) report("phase_kind", want.kind, got.kind);
			if (got.left !== want.left) report("time_left_us", want.left, got.left);
			if (got.fvalid !== want.fvalid) report("fraction_valid", want.fvalid, got.fvalid);
			if (got.permille !== want.permille) begin
				report("fraction_permille", want.permille, got.permille);
			end
			if (got.expired !== want.expired) report("just_expired", want.expired, got.expired);
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [MIN_W-1:0] wr_data;
	bit hold_req = 1'b0;
	logic [NOW_W-1:0] clock_us;
	phase_timer_scoreboard sb = new();

	ppt_in_if in_ch();
	ppt_out_if out_ch();

	pomodoro_phase_timer_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #5 clk = ~clk;

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [1:0] next_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) return CMD_RESET;
		if (r < 5) return CMD_SPARE;
		if (r < 52) return CMD_TAP;
		return CMD_TICK;
	endfunction

	// Times mostly move forward, often landing within 2 us of a running deadline,
	// with occasional jumps backward, to random values and near the top.
	function automatic logic [NOW_W-1:0] next_time();
		int r;
		logic [63:0] span;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			clock_us += NOW_W'($urandom_range(0, 2000));
		end else if (r < 55 && sb.run_st == RUN_RUNNING) begin
			clock_us = NOW_W'(64'(sb.deadline) + 64'($urandom_range(0, 4)) - 64'd2);
		end else if (r < 75) begin
			span = 64'(sb.total) + 64'd1;
			clock_us += NOW_W'({$urandom, $urandom} % span);
		end else if (r < 85) begin
			clock_us += NOW_W'($urandom);
		end else if (r < 90) begin
			clock_us -= NOW_W'($urandom_range(0, 1000000000));
		end else if (r < 95) begin
			clock_us = NOW_W'({$urandom, $urandom});
		end else begin
			clock_us = NOW_TOP - NOW_W'($urandom_range(0, 1000));
		end
		return clock_us;
	endfunction

	task automatic send(logic [1:0] c, logic [NOW_W-1:0] t, int gap);
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.cmd <= c;
		in_ch.now_us <= t;
		do @(posedge clk); while (!in_ch.ready);
		sb.take_command(c, t);
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_minutes(logic [IDX_W-1:0] idx, logic [MIN_W-1:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		sb.set_minutes(idx, val);
	endtask

	task automatic set_lengths(logic [MIN_W-1:0] f, logic [MIN_W-1:0] s, logic [MIN_W-1:0] l);
		drain();
		write_minutes(REG_FOCUS, f);
		write_minutes(REG_SHORT, s);
		write_minutes(REG_LONG, l);
	endtask

	task automatic run_phase(int count, bit squeeze);
		int i;
		bit burst;
		burst = 1'b0;
		for (i = 0; i < count; i++) begin
			if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
			if (squeeze && i == 40) hold_req = 1'b1;
			if (squeeze && i == 120) drain();
			if (squeeze && i >= 40 && i < 80) begin
				send(next_cmd(), next_time(), 0);
			end else begin
				send(next_cmd(), next_time(), burst ? 0 : idle_span());
			end
		end
	endtask

	task automatic directed();
		send(CMD_TICK, '0, idle_span());
		send(CMD_SPARE, NOW_TOP, idle_span());
		send(CMD_TAP, NOW_TOP, idle_span());
		send(CMD_TICK, NOW_TOP, idle_span());
		send(CMD_TAP, NOW_TOP, idle_span());
		send(CMD_TICK, '0, idle_span());
		send(CMD_TAP, '0, idle_span());
		send(CMD_TICK, 48'd1499999999, idle_span());
		send(CMD_TICK, '0, idle_span());
		send(CMD_TAP, 48'd1500000000, idle_span());
		send(CMD_TAP, 48'd1500000001, idle_span());
		send(CMD_TAP, 48'd5, idle_span());
		send(CMD_TICK, 48'd300000004, idle_span());
		send(CMD_SPARE, 48'd300000005, idle_span());
		send(CMD_TICK, 48'd300000006, idle_span());
		send(CMD_TAP, 48'd7, idle_span());
		send(CMD_TAP, 48'd1000, idle_span());
		// Pausing after time went backward leaves more than the whole phase.
		send(CMD_TAP, '0, idle_span());
		send(CMD_RESET, 48'd99, idle_span());
		send(CMD_RESET, NOW_TOP, idle_span());
		send(CMD_TAP, 48'd750000000, idle_span());
		send(CMD_TICK, 48'd1500000000, idle_span());
		clock_us = 48'd1500000000;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sb.check_report('{out_ch.timer_state, out_ch.step_index, out_ch.phase_kind,
				out_ch.time_left_us, out_ch.fraction_valid, out_ch.fraction_permille,
				out_ch.just_expired});
		end
	end

	initial begin
		int stall;
		int epoch;
		bit steady;
		out_ch.ready = 1'b0;
		stall = 0;
		epoch = 0;
		steady = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			epoch++;
			if (epoch % 150 == 0) steady = ($urandom_range(0, 3) == 0);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 4) == 0) begin
				stall = idle_span();
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_TICK;
		in_ch.now_us = '0;
		wr_en = 1'b0;
		wr_index = REG_FOCUS;
		wr_data = '0;
		clock_us = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed();
		run_phase(200, 1'b0);

		// The timer is usually mid-phase here; only the next start sees the new lengths.
		set_lengths(7'd1, 7'd1, 7'd1);
		write_minutes(REG_SPARE, 7'h7F);
		run_phase(320, 1'b0);

		set_lengths(7'd0, 7'd0, 7'd0);
		run_phase(60, 1'b0);

		set_lengths(7'h7F, 7'h7F, 7'h7F);
		run_phase(200, 1'b0);

		set_lengths(7'd99, 7'd1, 7'd2);
		run_phase(220, 1'b1);

		set_lengths(7'd0, 7'd3, 7'd1);
		run_phase(120, 1'b0);

		set_lengths(MIN_W'($urandom_range(1, 10)), MIN_W'($urandom_range(1, 10)),
			MIN_W'($urandom_range(1, 10)));
		write_minutes(REG_SPARE, 7'd0);
		run_phase(300, 1'b0);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl
rtl/ppt_pkg.sv
rtl/ppt_if.sv
rtl/ppt_alu.sv
rtl/ppt_ctrl.sv
rtl/pomodoro_phase_timer_top.sv
rtl/ppt_chk.sv
dv/pomodoro_phase_timer_top_test.sv
